/* rtl/wme_pkg.sv */
// Shared constants, types and helper functions of the wildcard message extractor.
package wme_pkg;

   localparam int PATTERN_MAX   = 16;
   localparam int MSG_DEPTH_DEF = 64;
   localparam int PATTERN_BITS  = 128;
   localparam int POS_W         = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 64;

   localparam logic [7:0] MARK_BYTE = 8'h24;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 2'd2;

   typedef struct packed {
      logic [PATTERN_BITS-1:0] pattern;
      logic [POS_W-1:0]        used_len;
   } wme_cfg_type;

   // Pattern byte at a position; positions at or past the length read as zero.
   function automatic logic [7:0] pat_at(input logic [PATTERN_BITS-1:0] pattern,
                                         input logic [POS_W-1:0] pos,
                                         input logic [POS_W-1:0] len);
      logic [7:0] r;
      if (pos >= len) begin
         r = 8'h00;
      end else begin
         r = pattern[{pos[3:0], 3'b000} +: 8];
      end
      return r;
   endfunction

endpackage

/* rtl/wildcard_message_extractor.sv */
// Top level of the wildcard message extractor: configuration registers and block wiring.
//
// The block matches a received byte stream against a pattern of up to 16 bytes
// held in the configuration registers; the first '$' in the pattern marks where
// capture starts, and on a full match the captured message is sent out one byte
// per beat, with last on the final beat, overflow on every beat if bytes were
// lost to a full buffer, and a single empty beat when nothing was captured. An
// input byte is normally accepted without a stall. A mismatch during capture
// that must first store held-back suffix bytes stalls input while those bytes
// and then the byte that broke the match are written one at a time, because
// the capture buffer memory has a single write port. A completed message
// occupies the buffer read port while its bytes are read out and handed on,
// which takes longer if the result side stalls; an empty result waits until
// the output register is free. Input is stalled during those phases only; a
// result waiting in the output register does not hold off the next byte. The
// buffer needs no clearing pass after reset, since only entries below the
// current capture length are ever read.
module wildcard_message_extractor
   import wme_pkg::*;
#(
   parameter int MSG_DEPTH = MSG_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_msg_byte,
   output logic                  rsp_last,
   output logic                  rsp_empty_res,
   output logic                  rsp_overflow
);

   localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;

   logic [63:0]      pattern_low_ff;
   logic [63:0]      pattern_high_ff;
   logic [POS_W-1:0] pattern_length_ff;
   logic [POS_W-1:0] used_len;
   wme_cfg_type      cfg;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [7:0]    mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [7:0]    mem_rd_data;

   // Writes to an index past the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         pattern_length_ff <= POS_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:    pattern_low_ff    <= csr_data;
            CSR_PATTERN_HIGH:   pattern_high_ff   <= csr_data;
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_data[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // A length of zero acts as one, and anything above the pattern size is clipped.
   always_comb begin
      used_len = pattern_length_ff;
      if (pattern_length_ff == '0) begin
         used_len = POS_W'(1);
      end else if (pattern_length_ff > POS_W'(PATTERN_MAX)) begin
         used_len = POS_W'(PATTERN_MAX);
      end
   end

   assign cfg.pattern  = {pattern_high_ff, pattern_low_ff};
   assign cfg.used_len = used_len;

   wme_seq #(
      .MSG_DEPTH (MSG_DEPTH),
      .AW        (AW)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_msg_byte  (rsp_msg_byte),
      .rsp_last      (rsp_last),
      .rsp_empty_res (rsp_empty_res),
      .rsp_overflow  (rsp_overflow),
      .mem_wr_en     (mem_wr_en),
      .mem_wr_addr   (mem_wr_addr),
      .mem_wr_data   (mem_wr_data),
      .mem_rd_en     (mem_rd_en),
      .mem_rd_addr   (mem_rd_addr),
      .mem_rd_data   (mem_rd_data)
   );

   // Writes happen only while matching or filling and reads only while emitting, so the
   // two ports never touch the same entry in the same cycle.
   wme_buf #(
      .MSG_DEPTH (MSG_DEPTH),
      .AW        (AW)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* rtl/wme_buf.sv */
// Capture buffer memory: one write port, one read port with registered read data.
module wme_buf
   import wme_pkg::*;
#(
   parameter int MSG_DEPTH = MSG_DEPTH_DEF,
   parameter int AW        = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem_ff [MSG_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/wme_seq.sv */
// Match sequencer: compares bytes, writes captured bytes and streams out messages.
module wme_seq
   import wme_pkg::*;
#(
   parameter int MSG_DEPTH = MSG_DEPTH_DEF,
   parameter int AW        = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  wme_cfg_type   cfg,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_in_byte,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_msg_byte,
   output logic          rsp_last,
   output logic          rsp_empty_res,
   output logic          rsp_overflow,
   output logic          mem_wr_en,
   output logic [AW-1:0] mem_wr_addr,
   output logic [7:0]    mem_wr_data,
   output logic          mem_rd_en,
   output logic [AW-1:0] mem_rd_addr,
   input  logic [7:0]    mem_rd_data
);

   localparam int LEN_W = $clog2(MSG_DEPTH + 1);
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(MSG_DEPTH);
   localparam logic [POS_W-1:0] PAT_MAX_POS = POS_W'(PATTERN_MAX);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_FILL  = 2'd1;
   localparam logic [1:0] ST_EMIT  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [POS_W-1:0] match_pos_ff, match_pos_in;
   logic [POS_W-1:0] restart_pos_ff, restart_pos_in;
   logic             capturing_ff, capturing_in;
   logic [LEN_W-1:0] cap_len_ff, cap_len_in;
   logic             dropped_ff, dropped_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rd_last_ff, rd_last_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [POS_W-1:0] fill_k_ff, fill_k_in;
   logic [POS_W-1:0] fill_end_ff, fill_end_in;
   logic [7:0]       fill_byte_ff, fill_byte_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_empty_ff, rsp_empty_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [7:0]       cur_pat;
   logic             start;
   logic             cap_eff;
   logic [POS_W-1:0] restart_eff;
   logic             hit;
   logic             full;
   logic [POS_W-1:0] fill_end_cand;
   logic             out_free;
   logic             keep_en;
   logic [7:0]       keep_data;
   logic             clear;

   assign cur_pat     = pat_at(cfg.pattern, match_pos_ff, cfg.used_len);
   assign start       = !capturing_ff && (cur_pat == MARK_BYTE);
   assign cap_eff     = capturing_ff || start;
   assign restart_eff = start ? (match_pos_ff + POS_W'(1)) : restart_pos_ff;
   assign hit         = (cur_pat == req_in_byte);
   assign full        = hit && (({1'b0, match_pos_ff} + 6'd1) >= {1'b0, cfg.used_len});
   assign fill_end_cand = (match_pos_ff > PAT_MAX_POS) ? PAT_MAX_POS : match_pos_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      match_pos_in   = match_pos_ff;
      restart_pos_in = restart_pos_ff;
      capturing_in   = capturing_ff;
      cap_len_in     = cap_len_ff;
      dropped_in     = dropped_ff;
      rd_idx_in      = rd_idx_ff;
      rd_pend_in     = rd_pend_ff;
      rd_last_in     = rd_last_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      fill_k_in      = fill_k_ff;
      fill_end_in    = fill_end_ff;
      fill_byte_in   = fill_byte_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_ovf_in     = rsp_ovf_ff;
      keep_en        = 1'b0;
      keep_data      = req_in_byte;
      clear          = 1'b0;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = rd_idx_ff[AW-1:0];
      mem_wr_en      = 1'b0;
      mem_wr_addr    = cap_len_ff[AW-1:0];
      mem_wr_data    = req_in_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (start) begin
                  capturing_in   = 1'b1;
                  restart_pos_in = restart_eff;
                  cap_len_in     = '0;
                  dropped_in     = 1'b0;
               end
               if (hit) begin
                  if (full) begin
                     if (!cap_eff || (cap_len_in == '0)) begin
                        state_in = ST_EMPTY;
                     end else begin
                        state_in  = ST_EMIT;
                        rd_idx_in = '0;
                     end
                  end else begin
                     match_pos_in = match_pos_ff + POS_W'(1);
                     if (cap_eff && (match_pos_ff < restart_eff)) begin
                        keep_en = 1'b1;
                     end
                  end
               end else begin
                  if (cap_eff) begin
                     if (restart_eff < fill_end_cand) begin
                        state_in     = ST_FILL;
                        fill_k_in    = restart_eff;
                        fill_end_in  = fill_end_cand;
                        fill_byte_in = req_in_byte;
                     end else begin
                        keep_en = 1'b1;
                     end
                  end
                  match_pos_in = restart_eff;
               end
            end
         end
         ST_FILL: begin
            // Held-back suffix bytes go in first, then the byte that broke the match.
            keep_en = 1'b1;
            if (fill_k_ff < fill_end_ff) begin
               keep_data = pat_at(cfg.pattern, fill_k_ff, cfg.used_len);
               fill_k_in = fill_k_ff + POS_W'(1);
            end else begin
               keep_data = fill_byte_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rd_pend_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = mem_rd_data;
               rsp_last_in  = rd_last_ff;
               rsp_empty_in = 1'b0;
               rsp_ovf_in   = dropped_ff;
               rd_pend_in   = 1'b0;
               if (rd_last_ff) begin
                  clear    = 1'b1;
                  state_in = ST_IDLE;
               end
            end
            if ((rd_idx_ff < cap_len_ff) && (!rd_pend_ff || out_free)) begin
               mem_rd_en  = 1'b1;
               rd_idx_in  = rd_idx_ff + LEN_W'(1);
               rd_pend_in = 1'b1;
               rd_last_in = ((rd_idx_ff + LEN_W'(1)) == cap_len_ff);
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = 8'h00;
               rsp_last_in  = 1'b1;
               rsp_empty_in = 1'b1;
               rsp_ovf_in   = 1'b0;
               clear        = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (keep_en) begin
         if (cap_len_in < DEPTH_LEN) begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cap_len_in[AW-1:0];
            mem_wr_data = keep_data;
            cap_len_in  = cap_len_in + LEN_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end

      if (clear) begin
         match_pos_in   = '0;
         restart_pos_in = '0;
         capturing_in   = 1'b0;
         cap_len_in     = '0;
         dropped_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         match_pos_ff   <= '0;
         restart_pos_ff <= '0;
         capturing_ff   <= 1'b0;
         cap_len_ff     <= '0;
         dropped_ff     <= 1'b0;
         rd_idx_ff      <= '0;
         rd_pend_ff     <= 1'b0;
         rd_last_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         match_pos_ff   <= match_pos_in;
         restart_pos_ff <= restart_pos_in;
         capturing_ff   <= capturing_in;
         cap_len_ff     <= cap_len_in;
         dropped_ff     <= dropped_in;
         rd_idx_ff      <= rd_idx_in;
         rd_pend_ff     <= rd_pend_in;
         rd_last_ff     <= rd_last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_k_ff    <= fill_k_in;
      fill_end_ff  <= fill_end_in;
      fill_byte_ff <= fill_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_msg_byte  = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_overflow  = rsp_ovf_ff;

endmodule
